@@ sv/keypad_code_lock_controller_macros.svh @@
// Assertion macros for the keypad code lock controller.
// Used by the top level; expects signals clk and rst in scope.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KCLC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define KCLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kclc_pkg.sv @@
// Shared types, codes and constants for the keypad code lock controller.
// No dependencies; used by every module of the block but kclc_fifo.
package kclc_pkg;

  // Defaults for top-level parameters
  localparam int MAX_DIGITS_DEFAULT  = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Reset values and thresholds
  localparam logic [3:0] WRONG_LIMIT_RESET = 4'd5;
  localparam int         STORED_LEN_RESET  = 4;
  localparam logic [3:0] DIGIT_MAX         = 4'd9;
  localparam logic [3:0] BUZZ_SHORT_BELOW  = 4'd3;
  localparam logic [3:0] BUZZ_MEDIUM_BELOW = 4'd5;

  // Key command codes
  localparam logic [1:0] CMD_DIGIT  = 2'd0;
  localparam logic [1:0] CMD_ENTER  = 2'd1;
  localparam logic [1:0] CMD_CHANGE = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  // Buzz classes
  localparam logic [1:0] BUZZ_SILENT = 2'd0;
  localparam logic [1:0] BUZZ_SHORT  = 2'd1;
  localparam logic [1:0] BUZZ_MEDIUM = 2'd2;
  localparam logic [1:0] BUZZ_LONG   = 2'd3;

  typedef enum logic [3:0] {
    ST_DIGIT     = 4'd0,
    ST_CANCEL    = 4'd1,
    ST_CHANGE    = 4'd2,
    ST_GRANTED   = 4'd3,
    ST_DENIED    = 4'd4,
    ST_ENTER_NEW = 4'd5,
    ST_OLD_WRONG = 4'd6,
    ST_BLANK     = 4'd7,
    ST_TOO_LONG  = 4'd8,
    ST_STORED    = 4'd9,
    ST_DISABLED  = 4'd10,
    ST_IGNORED   = 4'd11
  } status_t;

  typedef enum logic [1:0] {
    MODE_UNLOCK = 2'd0,
    MODE_VERIFY = 2'd1,
    MODE_NEW    = 2'd2
  } mode_t;

  // Classified key event passed from front to back
  typedef enum logic [2:0] {
    OP_DIGIT  = 3'd0,
    OP_IGNORE = 3'd1,
    OP_ENTER  = 3'd2,
    OP_CHANGE = 3'd3,
    OP_CANCEL = 3'd4
  } op_t;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] digit;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic [1:0] buzz_class;
    logic [1:0] mode_now;
    logic [3:0] fail_count;
    logic [3:0] entry_count;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } op_item_t;

  // Buzz class from the failure count
  function automatic logic [1:0] buzz_of(input logic [3:0] count);
    logic [1:0] b;
    if (count < BUZZ_SHORT_BELOW) begin
      b = BUZZ_SHORT;
    end else if (count < BUZZ_MEDIUM_BELOW) begin
      b = BUZZ_MEDIUM;
    end else begin
      b = BUZZ_LONG;
    end
    return b;
  endfunction

endpackage

@@ sv/kclc_fifo.sv @@
// Small register FIFO with push/full and pop/empty sides.
// Generic over item type; no package dependency.
module kclc_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t wr_item,
  input  logic  pop,
  output logic  empty,
  output item_t rd_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = slots[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/kclc_front.sv @@
// Front end: accepts key events, classifies them and queues them for the back end.
// Depends on kclc_pkg and kclc_fifo.
module kclc_front #(
  parameter int QUEUE_DEPTH = kclc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  kclc_pkg::in_item_t  key_event,
  input  logic                op_pop,
  output logic                op_empty,
  output kclc_pkg::op_item_t  op_item
);

  kclc_pkg::op_item_t classified;

  // Decode the command; out-of-range digits become ignore ops
  always_comb begin
    classified.digit = key_event.digit;
    unique case (key_event.command)
      kclc_pkg::CMD_DIGIT: begin
        classified.op = (key_event.digit > kclc_pkg::DIGIT_MAX) ?
                        kclc_pkg::OP_IGNORE : kclc_pkg::OP_DIGIT;
      end
      kclc_pkg::CMD_ENTER:  classified.op = kclc_pkg::OP_ENTER;
      kclc_pkg::CMD_CHANGE: classified.op = kclc_pkg::OP_CHANGE;
      kclc_pkg::CMD_CANCEL: classified.op = kclc_pkg::OP_CANCEL;
    endcase
  end

  // Queue between front and back
  kclc_fifo #(
    .item_t (kclc_pkg::op_item_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_op_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .wr_item (classified),
    .pop     (op_pop),
    .empty   (op_empty),
    .rd_item (op_item)
  );

endmodule

@@ sv/kclc_back.sv @@
// Back end: holds the lock state and executes one classified key event per cycle
// while an op is queued and the result queue has room. Depends on kclc_pkg.
module kclc_back #(
  parameter int MAX_DIGITS = kclc_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          wrong_limit,
  input  logic                op_empty,
  input  kclc_pkg::op_item_t  op_item,
  output logic                op_pop,
  input  logic                res_full,
  output logic                res_push,
  output kclc_pkg::out_item_t res_item,
  output logic                locked_out
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int LEN_W = $clog2(MAX_DIGITS + 2);

  logic [3:0]        stored_digits [MAX_DIGITS];
  logic [LEN_W-1:0]  stored_length;
  logic [3:0]        entry_digits [MAX_DIGITS];
  logic [LEN_W-1:0]  entry_length;
  kclc_pkg::mode_t   lock_mode;
  logic [3:0]        wrong_count;
  logic              disabled_flag;

  logic [LEN_W-1:0]  stored_length_next;
  logic [LEN_W-1:0]  entry_length_next;
  kclc_pkg::mode_t   lock_mode_next;
  logic [3:0]        wrong_count_next;
  logic              disabled_flag_next;

  logic              exec;
  logic              match;
  logic              can_count;
  logic              digit_write;
  logic              code_store;
  logic [MAX_DIGITS-1:0] pos_ok;
  logic [LEN_W+3:0]  len_wide;
  kclc_pkg::status_t status;
  logic [1:0]        buzz;

  assign exec       = !op_empty && !res_full;
  assign op_pop     = exec;
  assign res_push   = exec;
  assign locked_out = disabled_flag;
  assign can_count  = (wrong_count < wrong_limit);

  // Parallel compare of entry against stored code
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      pos_ok[i] = (LEN_W'(i) >= entry_length) || (entry_digits[i] == stored_digits[i]);
    end
  end
  assign match = (entry_length == stored_length) &&
                 (entry_length <= LEN_W'(MAX_DIGITS)) && (&pos_ok);

  // Mode next state
  always_comb begin
    lock_mode_next = lock_mode;
    if (exec && !disabled_flag) begin
      unique case (op_item.op)
        kclc_pkg::OP_CHANGE: lock_mode_next = kclc_pkg::MODE_VERIFY;
        kclc_pkg::OP_CANCEL: lock_mode_next = kclc_pkg::MODE_UNLOCK;
        kclc_pkg::OP_ENTER: begin
          unique case (lock_mode)
            kclc_pkg::MODE_VERIFY: begin
              if (match) begin
                lock_mode_next = kclc_pkg::MODE_NEW;
              end else if (can_count) begin
                lock_mode_next = kclc_pkg::MODE_UNLOCK;
              end
            end
            default: lock_mode_next = kclc_pkg::MODE_UNLOCK;
          endcase
        end
        default: lock_mode_next = lock_mode;
      endcase
    end
  end

  // Data path next values and result status
  always_comb begin
    stored_length_next = stored_length;
    entry_length_next  = entry_length;
    wrong_count_next   = wrong_count;
    disabled_flag_next = disabled_flag;
    digit_write        = 1'b0;
    code_store         = 1'b0;
    status             = kclc_pkg::ST_DISABLED;
    buzz               = kclc_pkg::BUZZ_SILENT;
    if (!disabled_flag) begin
      unique case (op_item.op)
        kclc_pkg::OP_IGNORE: status = kclc_pkg::ST_IGNORED;
        kclc_pkg::OP_DIGIT: begin
          status = kclc_pkg::ST_DIGIT;
          if (entry_length < LEN_W'(MAX_DIGITS)) begin
            digit_write       = 1'b1;
            entry_length_next = entry_length + LEN_W'(1);
          end else begin
            entry_length_next = LEN_W'(MAX_DIGITS + 1);
          end
        end
        kclc_pkg::OP_CHANGE: begin
          status            = kclc_pkg::ST_CHANGE;
          entry_length_next = '0;
        end
        kclc_pkg::OP_CANCEL: begin
          status            = kclc_pkg::ST_CANCEL;
          entry_length_next = '0;
        end
        default: begin
          entry_length_next = '0;
          if (lock_mode == kclc_pkg::MODE_NEW) begin
            if (entry_length == '0) begin
              status = kclc_pkg::ST_BLANK;
            end else if (entry_length > LEN_W'(MAX_DIGITS)) begin
              status = kclc_pkg::ST_TOO_LONG;
            end else begin
              status             = kclc_pkg::ST_STORED;
              code_store         = 1'b1;
              stored_length_next = entry_length;
            end
          end else if (match) begin
            if (lock_mode == kclc_pkg::MODE_VERIFY) begin
              status = kclc_pkg::ST_ENTER_NEW;
            end else begin
              status           = kclc_pkg::ST_GRANTED;
              wrong_count_next = '0;
            end
          end else if (can_count) begin
            // Counted failure
            wrong_count_next = wrong_count + 4'd1;
            buzz             = kclc_pkg::buzz_of(wrong_count + 4'd1);
            status           = (lock_mode == kclc_pkg::MODE_VERIFY) ?
                               kclc_pkg::ST_OLD_WRONG : kclc_pkg::ST_DENIED;
          end else begin
            // Limit reached: lock out until reset
            disabled_flag_next = 1'b1;
            buzz               = kclc_pkg::buzz_of(wrong_count);
            status             = kclc_pkg::ST_DISABLED;
          end
        end
      endcase
    end
  end

  // Result reports the state after the transaction
  assign len_wide = {4'd0, entry_length_next};
  always_comb begin
    res_item.status      = status;
    res_item.buzz_class  = buzz;
    res_item.mode_now    = lock_mode_next;
    res_item.fail_count  = wrong_count_next;
    res_item.entry_count = len_wide[3:0];
  end

  // Entry buffer, no reset
  always_ff @(posedge clk) begin
    if (exec && digit_write) begin
      entry_digits[entry_length[IDX_W-1:0]] <= op_item.digit;
    end
  end

  // Lock state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        stored_digits[i] <= '0;
      end
      stored_length <= LEN_W'(kclc_pkg::STORED_LEN_RESET);
      entry_length  <= '0;
      lock_mode     <= kclc_pkg::MODE_UNLOCK;
      wrong_count   <= '0;
      disabled_flag <= 1'b0;
    end else begin
      lock_mode <= lock_mode_next;
      if (exec) begin
        stored_length <= stored_length_next;
        entry_length  <= entry_length_next;
        wrong_count   <= wrong_count_next;
        disabled_flag <= disabled_flag_next;
        if (code_store) begin
          for (int i = 0; i < MAX_DIGITS; i++) begin
            stored_digits[i] <= entry_digits[i];
          end
        end
      end
    end
  end

endmodule

@@ sv/keypad_code_lock_controller.sv @@
// Keypad code lock controller, top level.
// Path: front queue, then the execute stage that owns all lock state, then the result queue.
// Throughput: one event per cycle unless the front queue is empty or the result
// queue is full; queues on both sides of the execute stage let either side stall alone.
// Reset (rst, synchronous): empties queues, code 0000 of length 4, limit 5, unlocked.
// Depends on kclc_pkg, kclc_front, kclc_back, kclc_fifo and the macros header.
`include "keypad_code_lock_controller_macros.svh"

module keypad_code_lock_controller #(
  parameter int MAX_DIGITS  = kclc_pkg::MAX_DIGITS_DEFAULT,
  parameter int QUEUE_DEPTH = kclc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  kclc_pkg::in_item_t  key_event,
  output logic                empty,
  input  logic                pop,
  output kclc_pkg::out_item_t result,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data
);

  logic                op_pop;
  logic                op_empty;
  kclc_pkg::op_item_t  op_item;
  logic                res_full;
  logic                res_push;
  kclc_pkg::out_item_t res_item;
  logic                locked_out;
  logic [3:0]          wrong_limit;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      wrong_limit <= kclc_pkg::WRONG_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      wrong_limit <= cfg_wr_data;
    end
  end

  kclc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .key_event (key_event),
    .op_pop    (op_pop),
    .op_empty  (op_empty),
    .op_item   (op_item)
  );

  kclc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wrong_limit (wrong_limit),
    .op_empty    (op_empty),
    .op_item     (op_item),
    .op_pop      (op_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_item    (res_item),
    .locked_out  (locked_out)
  );

  // Result queue
  kclc_fifo #(
    .item_t (kclc_pkg::out_item_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .full    (res_full),
    .wr_item (res_item),
    .pop     (pop),
    .empty   (empty),
    .rd_item (result)
  );

  // Checks
  `KCLC_ASSERT_NEXT(a_lockout_sticky, locked_out, locked_out,
                    "lockout flag cleared without reset")
  `KCLC_ASSERT_IMPLIES(a_locked_reports, res_push && locked_out,
                       (res_item.status == kclc_pkg::ST_DISABLED) &&
                       (res_item.buzz_class == kclc_pkg::BUZZ_SILENT),
                       "locked transaction not reported as disabled")
  `KCLC_ASSERT_IMPLIES(a_grant_clears, res_push && (res_item.status == kclc_pkg::ST_GRANTED),
                       (res_item.fail_count == 4'd0) &&
                       (res_item.mode_now == kclc_pkg::MODE_UNLOCK),
                       "grant left failure count or mode set")
  `KCLC_ASSERT_IMPLIES(a_buzz_on_fail,
                       res_push && (res_item.buzz_class != kclc_pkg::BUZZ_SILENT),
                       (res_item.status == kclc_pkg::ST_DENIED) ||
                       (res_item.status == kclc_pkg::ST_OLD_WRONG) ||
                       (res_item.status == kclc_pkg::ST_DISABLED),
                       "buzz without a failure")

endmodule

@@ dv/lock_response_checker.sv @@
// Checker for the keypad code lock controller: watches the key, result and
// configuration ports, predicts every lock response and compares it field by field.
// Depends on kclc_pkg; instantiated by the testbench top beside the block.
`timescale 1ns / 100ps

module lock_response_checker (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           push,
  input  logic                                           full,
  input  kclc_pkg::in_item_t                             key_event,
  input  logic                                           empty,
  input  logic                                           pop,
  input  kclc_pkg::out_item_t                            result,
  input  logic                                           cfg_wr_en,
  input  logic [3:0]                                     cfg_wr_data,
  output int                                             mismatch_count,
  output int                                             pending_results,
  // predicted lock state, used by the stimulus to steer its sequences
  output logic [kclc_pkg::MAX_DIGITS_DEFAULT-1:0][3:0]   code_digits,
  output int                                             code_length,
  output logic [3:0]                                     miss_tally,
  output kclc_pkg::mode_t                                lock_mode
);
  import kclc_pkg::*;

  localparam int DIGITS = MAX_DIGITS_DEFAULT;

  logic [DIGITS-1:0][3:0] entry_buf;
  int                     entry_len;
  logic                   locked_out;
  logic [3:0]             miss_limit;
  out_item_t              awaited_q[$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // Buzz grows with the number of misses since the last grant
  function automatic logic [1:0] buzz_for(input logic [3:0] misses);
    if (misses < BUZZ_SHORT_BELOW) return BUZZ_SHORT;
    if (misses < BUZZ_MEDIUM_BELOW) return BUZZ_MEDIUM;
    return BUZZ_LONG;
  endfunction

  // Exact match in length and digits; an overflowed entry never matches
  function automatic bit entry_is_code();
    if (entry_len != code_length || entry_len > DIGITS) return 1'b0;
    for (int i = 0; i < DIGITS; i++) begin
      if (i < entry_len && entry_buf[i] != code_digits[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Failed enter: count it, or lock out once the tally has reached the limit
  task automatic take_miss(input status_t miss_status, output status_t st,
                           output logic [1:0] buzz);
    entry_len = 0;
    if (miss_tally < miss_limit) begin
      miss_tally = miss_tally + 4'd1;
      lock_mode  = MODE_UNLOCK;
      st         = miss_status;
    end else begin
      locked_out = 1'b1;
      st         = ST_DISABLED;
    end
    buzz = buzz_for(miss_tally);
  endtask

  // One key event in, one lock response out
  task automatic predict_response(input in_item_t k, output out_item_t r);
    status_t    st;
    logic [1:0] buzz;
    buzz = BUZZ_SILENT;
    if (locked_out) begin
      st = ST_DISABLED;
    end else begin
      case (k.command)
        CMD_DIGIT: begin
          if (k.digit > DIGIT_MAX) begin
            st = ST_IGNORED;
          end else begin
            if (entry_len < DIGITS) begin
              entry_buf[entry_len] = k.digit;
              entry_len++;
            end else begin
              entry_len = DIGITS + 1;  // saturate, never matches
            end
            st = ST_DIGIT;
          end
        end
        CMD_CHANGE: begin
          lock_mode = MODE_VERIFY;
          entry_len = 0;
          st        = ST_CHANGE;
        end
        CMD_CANCEL: begin
          lock_mode = MODE_UNLOCK;
          entry_len = 0;
          st        = ST_CANCEL;
        end
        default: begin
          case (lock_mode)
            MODE_VERIFY: begin
              if (entry_is_code()) begin
                entry_len = 0;
                lock_mode = MODE_NEW;
                st        = ST_ENTER_NEW;
              end else begin
                take_miss(ST_OLD_WRONG, st, buzz);
              end
            end
            MODE_NEW: begin
              if (entry_len == 0) begin
                st = ST_BLANK;
              end else if (entry_len > DIGITS) begin
                st = ST_TOO_LONG;
              end else begin
                code_digits = entry_buf;
                code_length = entry_len;
                st          = ST_STORED;
              end
              entry_len = 0;
              lock_mode = MODE_UNLOCK;
            end
            default: begin
              lock_mode = MODE_UNLOCK;
              if (entry_is_code()) begin
                entry_len  = 0;
                miss_tally = '0;
                st         = ST_GRANTED;
              end else begin
                take_miss(ST_DENIED, st, buzz);
              end
            end
          endcase
        end
      endcase
    end
    r.status      = st;
    r.buzz_class  = buzz;
    r.mode_now    = lock_mode;
    r.fail_count  = miss_tally;
    r.entry_count = 4'(entry_len);
  endtask

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track configuration, compare results, predict accepted key events
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      miss_limit  = WRONG_LIMIT_RESET;
      code_digits = '0;
      code_length = STORED_LEN_RESET;
      entry_buf   = '0;
      entry_len   = 0;
      lock_mode   = MODE_UNLOCK;
      miss_tally  = '0;
      locked_out  = 1'b0;
      awaited_q.delete();
    end else begin
      if (cfg_wr_en) begin
        miss_limit = cfg_wr_data;
      end
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none, got %h",
                   $time, result);
          mismatch_count++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, result.status);
          check_field("buzz_class", 4'(want.buzz_class), 4'(result.buzz_class));
          check_field("mode_now", 4'(want.mode_now), 4'(result.mode_now));
          check_field("fail_count", want.fail_count, result.fail_count);
          check_field("entry_count", want.entry_count, result.entry_count);
        end
      end
      if (push && !full) begin
        predict_response(key_event, want);
        awaited_q.push_back(want);
      end
    end
    pending_results = awaited_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// Testbench top for the keypad code lock controller: drives key events and
// limit writes, stalls both sides at random and gives the verdict.
// Depends on kclc_pkg, the block and lock_response_checker.
`timescale 1ns / 100ps

module testbench;
  import kclc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                                clk;
  logic                                rst;
  logic                                push;
  logic                                full;
  in_item_t                            key_event;
  logic                                empty;
  logic                                pop;
  out_item_t                           result;
  logic                                cfg_wr_en;
  logic [3:0]                          cfg_wr_data;

  int                                  mismatch_count;
  int                                  pending_results;
  logic [MAX_DIGITS_DEFAULT-1:0][3:0]  code_digits;
  int                                  code_length;
  logic [3:0]                          miss_tally;
  mode_t                               lock_mode;

  int                                  send_idle_pct;
  int                                  recv_idle_pct;
  int                                  keys_sent;
  int                                  cycle_count;
  logic [3:0]                          miss_limit;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  keypad_code_lock_controller i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .key_event   (key_event),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lock_response_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .key_event       (key_event),
    .empty           (empty),
    .pop             (pop),
    .result          (result),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .code_digits     (code_digits),
    .code_length     (code_length),
    .miss_tally      (miss_tally),
    .lock_mode       (lock_mode)
  );

  // Result side stalls at random
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One key transaction; returns on the falling edge after acceptance
  task automatic send_key(input logic [1:0] cmd, input logic [3:0] dig);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    push      <= 1'b1;
    key_event <= '{command: cmd, digit: dig};
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_DIGIT || dig <= DIGIT_MAX) keys_sent++;
  endtask

  task automatic send_code();
    for (int i = 0; i < code_length; i++) begin
      send_key(CMD_DIGIT, code_digits[i]);
    end
  endtask

  // Random digits, now and then an out-of-range one
  task automatic send_digits(input int n);
    repeat (n) begin
      if ($urandom_range(19) == 0) send_key(CMD_DIGIT, 4'($urandom_range(15, 10)));
      else send_key(CMD_DIGIT, 4'($urandom_range(9)));
    end
  endtask

  task automatic grant_access();
    send_key(CMD_CANCEL, 4'($urandom_range(15)));
    send_code();
    send_key(CMD_ENTER, 4'($urandom_range(15)));
  endtask

  task automatic unlock_attempt();
    if ($urandom_range(9) < 7) send_key(CMD_CANCEL, 4'($urandom_range(15)));
    if ($urandom_range(2) == 0) send_code();
    else send_digits($urandom_range(12));
    send_key(CMD_ENTER, 4'($urandom_range(15)));
  endtask

  // Change key, the old code or random digits, then, if accepted, a new code of random length
  task automatic change_code();
    int pick;
    int n;
    send_key(CMD_CHANGE, 4'($urandom_range(15)));
    if ($urandom_range(9) < 8) send_code();
    else send_digits($urandom_range(5, 1));
    send_key(CMD_ENTER, 4'($urandom_range(15)));
    if (lock_mode != MODE_NEW) return;
    pick = $urandom_range(99);
    if (pick < 8) n = 0;
    else if (pick < 16) n = $urandom_range(12, 11);
    else if (pick < 30) n = MAX_DIGITS_DEFAULT;
    else n = $urandom_range(9, 1);
    send_digits(n);
    send_key(CMD_ENTER, 4'($urandom_range(15)));
  endtask

  // Arbitrary keys; an enter that could lock the block out becomes a cancel
  task automatic noise_burst();
    logic [1:0] cmd;
    repeat ($urandom_range(6, 1)) begin
      cmd = 2'($urandom_range(3));
      if (cmd == CMD_ENTER && miss_tally >= miss_limit) cmd = CMD_CANCEL;
      send_key(cmd, 4'($urandom_range(15)));
    end
  endtask

  task automatic run_random(input int n);
    int pick;
    int stop_at;
    stop_at = keys_sent + n;
    while (keys_sent < stop_at) begin
      // each sequence holds at most one failing enter, so one spare miss is enough
      if (miss_tally >= miss_limit) grant_access();
      pick = $urandom_range(99);
      if (pick < 40) unlock_attempt();
      else if (pick < 75) change_code();
      else noise_burst();
    end
  endtask

  // Limit write once all responses are back and the block has settled
  task automatic set_limit(input logic [3:0] v);
    push <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    miss_limit = v;
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    pop           = 1'b0;
    key_event     = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    keys_sent     = 0;
    cycle_count   = 0;
    miss_limit    = WRONG_LIMIT_RESET;
    send_idle_pct = 7;
    recv_idle_pct = 72;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: ignored digit, empty enter, grant, wrong and right old code,
    // blank new code, cancel
    send_key(CMD_DIGIT, 4'd15);
    send_key(CMD_ENTER, 4'd0);
    repeat (4) send_key(CMD_DIGIT, 4'd0);
    send_key(CMD_ENTER, 4'd0);
    send_key(CMD_CHANGE, 4'd0);
    send_key(CMD_DIGIT, 4'd9);
    send_key(CMD_ENTER, 4'd0);
    send_key(CMD_CHANGE, 4'd0);
    repeat (4) send_key(CMD_DIGIT, 4'd0);
    send_key(CMD_ENTER, 4'd0);
    send_key(CMD_ENTER, 4'd0);
    send_key(CMD_DIGIT, 4'd9);
    send_key(CMD_CANCEL, 4'd0);

    run_random(120);

    set_limit(4'd15);
    send_idle_pct = 72;
    recv_idle_pct = 7;
    run_random(120);

    set_limit(4'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(70);

    set_limit(4'd7);
    run_random(70);

    // Zero limit: the first miss locks the block out for good
    set_limit(4'd0);
    send_key(CMD_CANCEL, 4'd0);
    send_key(CMD_ENTER, 4'd0);
    repeat (30) send_key(2'($urandom_range(3)), 4'($urandom_range(15)));

    push <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending_results != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_results);
    end
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ keypad_code_lock_controller.f @@
+incdir+sv
sv/kclc_pkg.sv
sv/kclc_fifo.sv
sv/kclc_front.sv
sv/kclc_back.sv
sv/keypad_code_lock_controller.sv
dv/lock_response_checker.sv
dv/testbench.sv
